/* sv/rctd_pkg.sv */
// Package with the shared constants and types of the ring code target decoder.
`default_nettype none

package rctd_pkg;

  // Ring geometry.
  localparam int SAMPLE_COUNT = 60;
  localparam int CODE_BITS = 15;
  localparam int GROUP_SIZE = SAMPLE_COUNT / CODE_BITS;

  // The start pattern 0,1,1,1,0 takes the first five code bits; the rest form the id.
  localparam int START_LEN = 5;
  localparam int ID_BITS = CODE_BITS - START_LEN;

  // Width of a rotation amount and of a per-group white count.
  localparam int SEL_W = $clog2(CODE_BITS);
  localparam int CNT_W = $clog2(GROUP_SIZE + 2);

  // A group votes 1 when its white count exceeds half its size.
  localparam logic [CNT_W-1:0] VOTE_HALF = CNT_W'(GROUP_SIZE / 2);

  // Expected low bits of an aligned code.
  localparam logic [START_LEN-1:0] START_PATTERN = 5'b01110;

  typedef logic [SAMPLE_COUNT-1:0] samples_t;
  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [SEL_W-1:0] sel_t;

  // Decoded bits with the chosen start position, passed to the alignment stage.
  typedef struct packed {
    code_t bits;
    sel_t  sel;
    logic  hit;
  } match_t;

endpackage

`default_nettype wire

/* sv/rctd_in_if.sv */
// Request channel that carries the ring samples into the decoder.
`default_nettype none

interface rctd_in_if;
  import rctd_pkg::*;

  logic     valid;
  logic     ready;
  samples_t ring_samples;

  modport source (output valid, output ring_samples, input ready);
  modport sink (input valid, input ring_samples, output ready);

endinterface

`default_nettype wire

/* sv/rctd_out_if.sv */
// Request channel that carries the decoded target out of the decoder.
`default_nettype none

interface rctd_out_if;
  import rctd_pkg::*;

  logic  valid;
  logic  ready;
  id_t   target_id;
  code_t aligned_code;
  logic  found;

  modport source (output valid, output target_id, output aligned_code, output found,
                  input ready);
  modport sink (input valid, input target_id, input aligned_code, input found,
                output ready);

endinterface

`default_nettype wire

/* sv/rctd_vote.sv */
// Pipeline stage that turns each group of ring samples into one code bit by majority.
`default_nettype none

module rctd_vote (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  rctd_pkg::samples_t  samples,
  output logic                out_valid,
  input  wire                 out_ready,
  output rctd_pkg::code_t     bits
);
  import rctd_pkg::*;

  code_t bits_next;

  // Count white samples in every group and compare against half the group.
  always_comb begin
    logic [CNT_W-1:0] white;
    white = '0;
    bits_next = '0;
    for (int b = 0; b < CODE_BITS; b++) begin
      white = '0;
      for (int s = 0; s < GROUP_SIZE; s++) begin
        white = white + CNT_W'(samples[b * GROUP_SIZE + s]);
      end
      bits_next[b] = (white > VOTE_HALF);
    end
  end

  // The stage takes a new request when it is empty or its content moves on.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      bits <= bits_next;
    end
  end

endmodule

`default_nettype wire

/* sv/rctd_match.sv */
// Two pipeline stages: start pattern detection at every position, then the last-match pick.
`default_nettype none

module rctd_match (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  rctd_pkg::code_t   bits,
  output logic              out_valid,
  input  wire               out_ready,
  output rctd_pkg::match_t  match
);
  import rctd_pkg::*;

  code_t  flags_next;
  code_t  flags;
  code_t  held_bits;
  logic   det_valid;
  logic   det_ready;
  match_t match_next;

  // A position matches when the five cyclically following bits read 0,1,1,1,0.
  always_comb begin
    for (int b = 0; b < CODE_BITS; b++) begin
      flags_next[b] = !bits[b]
                      && bits[(b + 1) % CODE_BITS]
                      && bits[(b + 2) % CODE_BITS]
                      && bits[(b + 3) % CODE_BITS]
                      && !bits[(b + 4) % CODE_BITS];
    end
  end

  // Detection stage registers.
  assign in_ready = !det_valid || det_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_valid <= 1'b0;
    end else if (in_ready) begin
      det_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      flags <= flags_next;
      held_bits <= bits;
    end
  end

  // The highest matching position wins.
  always_comb begin
    match_next.bits = held_bits;
    match_next.hit = |flags;
    match_next.sel = '0;
    for (int b = 0; b < CODE_BITS; b++) begin
      if (flags[b]) begin
        match_next.sel = SEL_W'(b);
      end
    end
  end

  // Selection stage registers.
  assign det_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (det_ready) begin
      out_valid <= det_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (det_ready && det_valid) begin
      match <= match_next;
    end
  end

endmodule

`default_nettype wire

/* sv/rctd_align.sv */
// Output stage that rotates the code to its start pattern and packs the target id.
`default_nettype none

module rctd_align (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  rctd_pkg::match_t  match,
  output logic              out_valid,
  input  wire               out_ready,
  output rctd_pkg::id_t     target_id,
  output rctd_pkg::code_t   aligned_code,
  output logic              found
);
  import rctd_pkg::*;

  logic [2*CODE_BITS-1:0] doubled;
  code_t                  code_next;
  id_t                    id_next;

  // Rotate right by the start position over a doubled copy; zero when nothing matched.
  always_comb begin
    doubled = {match.bits, match.bits} >> match.sel;
    code_next = match.hit ? doubled[CODE_BITS-1:0] : '0;
    for (int n = START_LEN; n < CODE_BITS; n++) begin
      id_next[CODE_BITS - 1 - n] = code_next[n];
    end
  end

  // Output register; it holds a result until the sink takes it.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      target_id <= id_next;
      aligned_code <= code_next;
      found <= match.hit;
    end
  end

endmodule

`default_nettype wire

/* sv/ring_code_target_decoder.sv */
// Throughput: one ring per cycle while the output is not stalled; four register stages
// (vote, detect, select, align) each advance whenever they are empty or their content moves on.
// A stalled output holds its result while earlier stages keep filling empty slots.
// Reset (synchronous, active high) clears all stage valid bits; the data registers are not reset.
`default_nettype none

module ring_code_target_decoder (
  input  wire        clk,
  input  wire        rst,
  rctd_in_if.sink    ring,
  rctd_out_if.source result
);
  import rctd_pkg::*;

  logic   vote_valid;
  logic   vote_ready;
  code_t  vote_bits;
  logic   match_valid;
  logic   match_ready;
  match_t match;

  // Majority vote per group.
  rctd_vote u_vote (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ring.valid),
    .in_ready  (ring.ready),
    .samples   (ring.ring_samples),
    .out_valid (vote_valid),
    .out_ready (vote_ready),
    .bits      (vote_bits)
  );

  // Start pattern search.
  rctd_match u_match (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vote_valid),
    .in_ready  (vote_ready),
    .bits      (vote_bits),
    .out_valid (match_valid),
    .out_ready (match_ready),
    .match     (match)
  );

  // Rotation and id packing.
  rctd_align u_align (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (match_valid),
    .in_ready     (match_ready),
    .match        (match),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .target_id    (result.target_id),
    .aligned_code (result.aligned_code),
    .found        (result.found)
  );

endmodule

`default_nettype wire

/* sv/rctd_checker.sv */
// Port-level checker for the ring code target decoder, bound to the top level.
`default_nettype none

module rctd_checker (
  input wire              clk,
  input wire              rst,
  input wire              out_valid,
  input wire              out_ready,
  input rctd_pkg::id_t    target_id,
  input rctd_pkg::code_t  aligned_code,
  input wire              found
);
  import rctd_pkg::*;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  // Without a start pattern the result is all zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> target_id == '0 && aligned_code == '0)
    else $error("nonzero code without a start pattern");

  // A found code begins with the start pattern.
  a_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> aligned_code[START_LEN-1:0] == START_PATTERN)
    else $error("aligned code does not begin with the start pattern");

  // The id is the upper code bits in reverse order.
  a_id_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> target_id[ID_BITS-1] == aligned_code[START_LEN]
                  && target_id[0] == aligned_code[CODE_BITS-1])
    else $error("target id does not match the aligned code");

endmodule

bind ring_code_target_decoder rctd_checker u_rctd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .target_id    (result.target_id),
  .aligned_code (result.aligned_code),
  .found        (result.found)
);

`default_nettype wire
